// ===== design/xed_pkg.sv =====
// Shared types and constants of the XML character reference decoder.
// No dependencies; the front end, queue, back end, top level and testbench import it.
package xed_pkg;

    // Default buffer depth for pending reference bytes
    localparam int PENDING_MAX_DEF = 32;
    // Width of the flush count carried in a command (covers depths up to 127)
    localparam int CMD_CNT_W = 7;
    // Width of a code point
    localparam int VAL_W = 21;
    // Entries of the command queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;

    localparam logic [VAL_W-1:0] CODE_MAX = 21'h10FFFF;
    localparam logic [VAL_W-1:0] SURR_LO  = 21'h00D800;
    localparam logic [VAL_W-1:0] SURR_HI  = 21'h00DFFF;

    localparam logic [7:0] CH_AMP = 8'h26;

    // Matching phase of the front end
    typedef enum logic [2:0] {
        M_IDLE,
        M_NAME,
        M_HASH,
        M_WS,
        M_SIGN,
        M_ZERO,
        M_PREFIX,
        M_DIGITS
    } t_mode;

    // What the back end emits after the flushed bytes
    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_BYTE,
        TAIL_UTF8,
        TAIL_END
    } t_tail;

    // Back end sequencer state
    typedef enum logic [1:0] {
        B_IDLE,
        B_FLUSH,
        B_TAIL
    } t_bstate;

    // One command: replay flush_cnt pending bytes, then the tail
    typedef struct packed {
        logic [CMD_CNT_W-1:0] flush_cnt;
        t_tail                tail;
        logic [VAL_W-1:0]     value;
    } t_cmd;

endpackage

// ===== design/xed_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module xed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/xed_front.sv =====
// Front end: accepts input bytes, runs the reference matcher, stores pending bytes
// and issues at most one command per transaction. Depends on xed_pkg; writes the pending RAM.
module xed_front #(
    parameter int PENDING_MAX = xed_pkg::PENDING_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_func,
    input  logic [7:0]                     i_byte,
    // command queue
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output xed_pkg::t_cmd                  o_q_cmd,
    // back end finished replaying the buffer
    input  logic                           i_flush_done,
    // pending RAM write port
    output logic                           o_wr_en,
    output logic [$clog2(PENDING_MAX)-1:0] o_wr_addr,
    output logic [7:0]                     o_wr_data
);
    import xed_pkg::*;

    localparam int AW = $clog2(PENDING_MAX);
    localparam int CW = $clog2(PENDING_MAX + 1);
    localparam int ACC_W = VAL_W + 4;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        A_FAIL,
        A_PUSH,
        A_COMPLETE,
        A_NAMED,
        A_END
    } t_act;

    // Named entity text after the '&'
    function automatic logic [7:0] ent_at(input logic [2:0] k, input logic [2:0] i);
        logic [7:0] r;
        r = 8'h00;
        case (k)
            3'd0: case (i)  // amp;
                3'd0:    r = 8'h61;
                3'd1:    r = 8'h6D;
                3'd2:    r = 8'h70;
                3'd3:    r = 8'h3B;
                default: r = 8'h00;
            endcase
            3'd1: case (i)  // lt;
                3'd0:    r = 8'h6C;
                3'd1:    r = 8'h74;
                3'd2:    r = 8'h3B;
                default: r = 8'h00;
            endcase
            3'd2: case (i)  // gt;
                3'd0:    r = 8'h67;
                3'd1:    r = 8'h74;
                3'd2:    r = 8'h3B;
                default: r = 8'h00;
            endcase
            3'd3: case (i)  // quot;
                3'd0:    r = 8'h71;
                3'd1:    r = 8'h75;
                3'd2:    r = 8'h6F;
                3'd3:    r = 8'h74;
                3'd4:    r = 8'h3B;
                default: r = 8'h00;
            endcase
            3'd4: case (i)  // apos;
                3'd0:    r = 8'h61;
                3'd1:    r = 8'h70;
                3'd2:    r = 8'h6F;
                3'd3:    r = 8'h73;
                3'd4:    r = 8'h3B;
                default: r = 8'h00;
            endcase
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] ent_len(input logic [2:0] k);
        logic [2:0] r;
        case (k)
            3'd0:    r = 3'd4;
            3'd1:    r = 3'd3;
            3'd2:    r = 3'd3;
            default: r = 3'd5;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ent_char(input logic [2:0] k);
        logic [7:0] r;
        case (k)
            3'd0:    r = 8'h26;
            3'd1:    r = 8'h3C;
            3'd2:    r = 8'h3E;
            3'd3:    r = 8'h22;
            default: r = 8'h27;
        endcase
        return r;
    endfunction

    // Matcher state
    t_mode            r_mode, n_mode;
    logic [2:0]       r_idx, n_idx;
    logic [4:0]       r_cand, n_cand;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [VAL_W-1:0] r_val, n_val;
    logic             r_ovf, n_ovf;
    logic             r_hex, n_hex;
    logic             r_neg, n_neg;
    logic             r_busy, n_busy;

    logic [7:0]       ch;
    logic             accept;
    logic             sp, is_x, is_semi, is_sign;
    logic             dec_ok, hx_ok, dg_ok;
    logic [3:0]       hx_d, dg_d;
    logic [4:0]       cand_new;
    logic             hit;
    logic [7:0]       hit_ch;
    logic [ACC_W-1:0] acc;
    logic             acc_ovf;
    t_act             act;
    logic             ws_path, dig_path;
    t_mode            p_mode;
    logic [2:0]       p_idx;
    logic [4:0]       p_cand;
    logic [VAL_W-1:0] p_val;
    logic             p_ovf, p_hex, p_neg;
    logic             ref_ok, surrogate;
    t_cmd             cmd;
    logic             clear, start_amp, do_push;

    assign ch     = i_byte;
    assign o_ready = !i_q_full && !r_busy;
    assign accept  = i_valid && o_ready;

    // Byte classes and digit values
    always_comb begin
        sp      = (ch == CH_SPACE) || (ch >= 8'h09 && ch <= 8'h0D);
        is_x    = (ch == 8'h78) || (ch == 8'h58);
        is_semi = (ch == CH_SEMI);
        is_sign = (ch == CH_PLUS) || (ch == CH_MINUS);
        dec_ok  = (ch >= 8'h30 && ch <= 8'h39);
        hx_ok   = dec_ok;
        hx_d    = ch[3:0];
        if (ch >= 8'h61 && ch <= 8'h66) begin
            hx_ok = 1'b1;
            hx_d  = 4'(ch - 8'h57);
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            hx_ok = 1'b1;
            hx_d  = 4'(ch - 8'h37);
        end
        dg_ok = r_hex ? hx_ok : dec_ok;
        dg_d  = hx_d;
    end

    // Named entity candidates still alive after this byte
    always_comb begin
        cand_new = '0;
        hit      = 1'b0;
        hit_ch   = 8'h00;
        for (int k = 0; k < 5; k++) begin
            if (r_cand[k] && (r_idx < ent_len(3'(k))) && (ent_at(3'(k), r_idx) == ch)) begin
                cand_new[k] = 1'b1;
            end
            if (cand_new[k] && (ent_len(3'(k)) == r_idx + 3'd1)) begin
                hit    = 1'b1;
                hit_ch = ent_char(3'(k));
            end
        end
    end

    // Digit accumulation: value * base + digit
    always_comb begin
        if (r_hex) begin
            acc = {r_val, 4'b0000} + ACC_W'(dg_d);
        end else begin
            acc = ACC_W'({r_val, 3'b000}) + ACC_W'({r_val, 1'b0}) + ACC_W'(dg_d);
        end
        acc_ovf = (acc > ACC_W'(CODE_MAX));
    end

    // Action decode per matching phase
    always_comb begin
        act      = A_FAIL;
        ws_path  = 1'b0;
        dig_path = 1'b0;
        p_mode   = r_mode;
        p_idx    = r_idx;
        p_cand   = r_cand;
        p_val    = r_val;
        p_ovf    = r_ovf;
        p_hex    = r_hex;
        p_neg    = r_neg;
        if (i_func) begin
            act = A_END;
        end else begin
            unique case (r_mode)
                M_IDLE: act = A_FAIL;
                M_NAME: begin
                    if (r_idx == 3'd0 && ch == CH_HASH) begin
                        act    = A_PUSH;
                        p_mode = M_HASH;
                    end else if (cand_new == 5'd0) begin
                        act = A_FAIL;
                    end else if (hit) begin
                        act = A_NAMED;
                    end else begin
                        act    = A_PUSH;
                        p_mode = M_NAME;
                        p_cand = cand_new;
                        p_idx  = r_idx + 3'd1;
                    end
                end
                M_HASH: begin
                    if (is_x) begin
                        act    = A_PUSH;
                        p_mode = M_WS;
                        p_hex  = 1'b1;
                    end else begin
                        ws_path = 1'b1;
                    end
                end
                M_WS:   ws_path = 1'b1;
                M_SIGN: dig_path = 1'b1;
                M_ZERO: begin
                    if (is_x) begin
                        act    = A_PUSH;
                        p_mode = M_PREFIX;
                    end else if (is_semi) begin
                        act = A_COMPLETE;
                    end else if (hx_ok) begin
                        act    = A_PUSH;
                        p_mode = M_DIGITS;
                        p_val  = VAL_W'(hx_d);
                    end else begin
                        act = A_FAIL;
                    end
                end
                M_PREFIX: begin
                    if (hx_ok) begin
                        act    = A_PUSH;
                        p_mode = M_DIGITS;
                        p_val  = VAL_W'(hx_d);
                    end else begin
                        act = A_FAIL;
                    end
                end
                M_DIGITS: begin
                    if (is_semi) begin
                        act = A_COMPLETE;
                    end else if (!dg_ok) begin
                        act = A_FAIL;
                    end else begin
                        act    = A_PUSH;
                        p_mode = M_DIGITS;
                        if (!r_ovf) begin
                            if (acc_ovf) begin
                                p_ovf = 1'b1;
                            end else begin
                                p_val = acc[VAL_W-1:0];
                            end
                        end
                    end
                end
                default: act = A_FAIL;
            endcase
            // whitespace and sign phase (decimal form enters here from '#')
            if (ws_path) begin
                if (sp) begin
                    act    = A_PUSH;
                    p_mode = M_WS;
                end else if (is_sign) begin
                    act    = A_PUSH;
                    p_mode = M_SIGN;
                    p_neg  = (ch == CH_MINUS);
                end else begin
                    dig_path = 1'b1;
                end
            end
            // first character of the number
            if (dig_path) begin
                if (r_hex && ch == CH_ZERO) begin
                    act    = A_PUSH;
                    p_mode = M_ZERO;
                    p_val  = '0;
                end else if (dg_ok) begin
                    act    = A_PUSH;
                    p_mode = M_DIGITS;
                    p_val  = VAL_W'(dg_d);
                end else begin
                    act = A_FAIL;
                end
            end
        end
        // buffer full turns a push into a failed match
        if (act == A_PUSH && r_cnt >= CW'(PENDING_MAX)) begin
            act = A_FAIL;
        end
        ref_ok    = !r_neg && !r_ovf && (r_val != '0) && (r_val <= CODE_MAX);
        surrogate = (r_val >= SURR_LO) && (r_val <= SURR_HI);
        if (act == A_COMPLETE && !ref_ok) begin
            act = A_FAIL;
        end
    end

    // Command build and next matcher state
    always_comb begin
        cmd.flush_cnt = '0;
        cmd.tail      = TAIL_NONE;
        cmd.value     = '0;
        clear         = 1'b0;
        start_amp     = 1'b0;
        do_push       = 1'b0;
        unique case (act)
            A_FAIL: begin
                cmd.flush_cnt = CMD_CNT_W'(r_cnt);
                clear         = 1'b1;
                if (ch == CH_AMP) begin
                    start_amp = 1'b1;
                end else begin
                    cmd.tail  = TAIL_BYTE;
                    cmd.value = VAL_W'(ch);
                end
            end
            A_END: begin
                cmd.flush_cnt = CMD_CNT_W'(r_cnt);
                cmd.tail      = TAIL_END;
                clear         = 1'b1;
            end
            A_NAMED: begin
                cmd.tail  = TAIL_BYTE;
                cmd.value = VAL_W'(hit_ch);
                clear     = 1'b1;
            end
            A_COMPLETE: begin
                clear = 1'b1;
                if (!surrogate) begin
                    cmd.tail  = TAIL_UTF8;
                    cmd.value = r_val;
                end
            end
            A_PUSH:  do_push = 1'b1;
            default: clear = 1'b1;
        endcase

        n_mode = r_mode;
        n_idx  = r_idx;
        n_cand = r_cand;
        n_cnt  = r_cnt;
        n_val  = r_val;
        n_ovf  = r_ovf;
        n_hex  = r_hex;
        n_neg  = r_neg;
        n_busy = r_busy;
        if (i_flush_done) begin
            n_busy = 1'b0;
        end
        if (accept) begin
            if (clear) begin
                n_mode = M_IDLE;
                n_idx  = '0;
                n_cand = '0;
                n_cnt  = '0;
                n_val  = '0;
                n_ovf  = 1'b0;
                n_hex  = 1'b0;
                n_neg  = 1'b0;
            end
            if (start_amp) begin
                n_mode = M_NAME;
                n_cand = 5'h1F;
                n_cnt  = CW'(1);
            end
            if (do_push) begin
                n_mode = p_mode;
                n_idx  = p_idx;
                n_cand = p_cand;
                n_cnt  = r_cnt + CW'(1);
                n_val  = p_val;
                n_ovf  = p_ovf;
                n_hex  = p_hex;
                n_neg  = p_neg;
            end
            // hold input until the back end has replayed the buffer
            if (cmd.flush_cnt != '0) begin
                n_busy = 1'b1;
            end
        end
    end

    assign o_q_push  = accept && ((cmd.flush_cnt != '0) || (cmd.tail != TAIL_NONE));
    assign o_q_cmd   = cmd;
    // leading '&' is implied, so the RAM holds buffer slots from one up
    assign o_wr_en   = accept && do_push;
    assign o_wr_addr = r_cnt[AW-1:0];
    assign o_wr_data = ch;

    // Matcher registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_idx  <= '0;
            r_cand <= '0;
            r_cnt  <= '0;
            r_val  <= '0;
            r_ovf  <= 1'b0;
            r_hex  <= 1'b0;
            r_neg  <= 1'b0;
            r_busy <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_idx  <= n_idx;
            r_cand <= n_cand;
            r_cnt  <= n_cnt;
            r_val  <= n_val;
            r_ovf  <= n_ovf;
            r_hex  <= n_hex;
            r_neg  <= n_neg;
            r_busy <= n_busy;
        end
    end

endmodule

// ===== design/xed_queue.sv =====
// Short command queue between the front and back ends of the decoder.
// Depends on xed_pkg for the command type and depth.
module xed_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  xed_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output xed_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import xed_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_num;
    logic          do_wr, do_rd;

    assign o_full  = (r_num == NW'(QUEUE_DEPTH));
    assign o_empty = (r_num == '0);
    assign do_wr   = i_push && !o_full;
    assign do_rd   = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_num <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + PW'(1);
            end
            if (do_rd) begin
                r_rp <= r_rp + PW'(1);
            end
            if (do_wr && !do_rd) begin
                r_num <= r_num + NW'(1);
            end else if (do_rd && !do_wr) begin
                r_num <= r_num - NW'(1);
            end
        end
    end

endmodule

// ===== design/xed_back.sv =====
// Back end: executes commands, replays pending bytes from the RAM and encodes
// UTF-8, feeding the output register. Depends on xed_pkg.
module xed_back #(
    parameter int PENDING_MAX = xed_pkg::PENDING_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command queue
    input  logic                           i_q_empty,
    output logic                           o_q_pop,
    input  xed_pkg::t_cmd                  i_q_cmd,
    // pending RAM read port
    output logic [$clog2(PENDING_MAX)-1:0] o_rd_addr,
    input  logic [7:0]                     i_rd_data,
    output logic                           o_flush_done,
    // output stream
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [7:0]                     o_data,
    output logic                           o_end,
    output logic                           o_last
);
    import xed_pkg::*;

    localparam int AW = $clog2(PENDING_MAX);
    localparam int CW = $clog2(PENDING_MAX + 1);

    localparam logic [VAL_W-1:0] LIM1 = 21'h000080;
    localparam logic [VAL_W-1:0] LIM2 = 21'h000800;
    localparam logic [VAL_W-1:0] LIM3 = 21'h010000;

    t_bstate       r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [CW-1:0] r_idx, n_idx;
    logic [1:0]    r_pos, n_pos;
    logic          r_out_valid;
    logic [7:0]    r_out_data;
    logic          r_out_end, r_out_last;

    logic          slot_free, fin, emit, e_end, e_last;
    logic [7:0]    e_data, u_byte;
    logic [1:0]    nbm1, sh;

    assign slot_free = !r_out_valid || i_ready;

    // UTF-8 byte at position r_pos of the current code point
    always_comb begin
        if (r_cmd.value < LIM1) begin
            nbm1 = 2'd0;
        end else if (r_cmd.value < LIM2) begin
            nbm1 = 2'd1;
        end else if (r_cmd.value < LIM3) begin
            nbm1 = 2'd2;
        end else begin
            nbm1 = 2'd3;
        end
        sh = nbm1 - r_pos;
        if (r_pos == 2'd0) begin
            unique case (nbm1)
                2'd0:    u_byte = {1'b0, r_cmd.value[6:0]};
                2'd1:    u_byte = {3'b110, r_cmd.value[10:6]};
                2'd2:    u_byte = {4'b1110, r_cmd.value[15:12]};
                default: u_byte = {5'b11110, r_cmd.value[20:18]};
            endcase
        end else begin
            case (sh)
                2'd0:    u_byte = {2'b10, r_cmd.value[5:0]};
                2'd1:    u_byte = {2'b10, r_cmd.value[11:6]};
                default: u_byte = {2'b10, r_cmd.value[17:12]};
            endcase
        end
    end

    // Sequencer: next state and emitted byte
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_pos        = r_pos;
        o_q_pop      = 1'b0;
        o_flush_done = 1'b0;
        emit         = 1'b0;
        e_data       = 8'h00;
        e_end        = 1'b0;
        e_last       = 1'b0;
        fin          = (CMD_CNT_W'(r_idx) + CMD_CNT_W'(1) == r_cmd.flush_cnt);
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_idx   = '0;
                    n_pos   = '0;
                    n_state = (i_q_cmd.flush_cnt != '0) ? B_FLUSH : B_TAIL;
                end
            end
            B_FLUSH: begin
                if (slot_free) begin
                    emit   = 1'b1;
                    e_data = (r_idx == '0) ? CH_AMP : i_rd_data;
                    e_last = fin && (r_cmd.tail == TAIL_NONE);
                    n_idx  = r_idx + CW'(1);
                    if (fin) begin
                        o_flush_done = 1'b1;
                        n_state      = (r_cmd.tail == TAIL_NONE) ? B_IDLE : B_TAIL;
                    end
                end
            end
            B_TAIL: begin
                if (slot_free) begin
                    unique case (r_cmd.tail)
                        TAIL_BYTE: begin
                            emit    = 1'b1;
                            e_data  = r_cmd.value[7:0];
                            e_last  = 1'b1;
                            n_state = B_IDLE;
                        end
                        TAIL_END: begin
                            emit    = 1'b1;
                            e_end   = 1'b1;
                            e_last  = 1'b1;
                            n_state = B_IDLE;
                        end
                        TAIL_UTF8: begin
                            emit   = 1'b1;
                            e_data = u_byte;
                            e_last = (r_pos == nbm1);
                            n_pos  = r_pos + 2'd1;
                            if (r_pos == nbm1) begin
                                n_state = B_IDLE;
                            end
                        end
                        default: n_state = B_IDLE;
                    endcase
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Read address follows the next index so the registered read data lines up with r_idx
    assign o_rd_addr = n_idx[AW-1:0];

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_pos <= n_pos;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (emit) begin
            r_out_data <= e_data;
            r_out_end  <= e_end;
            r_out_last <= e_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_end   = r_out_end;
    assign o_last  = r_out_last;

endmodule

// ===== design/xml_entity_decoder_utf8_core.sv =====
// Top level of the XML character reference decoder with UTF-8 output.
// Depends on xed_pkg, xed_front, xed_queue, xed_ram and xed_back.
//
//  Channel   Dir  tdata              tuser               tlast
//  s_axis    in   in_byte [7:0]      func (1 = end)      -
//  m_axis    out  out_byte [7:0]     is_end_marker       last_of_run
//
// An input byte that opens or extends a reference, or maps to one output byte,
// is taken without hold-off unless the command queue is full; the back end loads
// each command, then emits one output byte per cycle while the output is not stalled
// (a UTF-8 sequence is 1 to 4 bytes). A failed match replays n buffered bytes: the
// input holds off until the last of them leaves the back end.
// Reset is synchronous and active low; the pending RAM needs no clearing pass.
// The output register lets the front keep taking bytes while a result waits.
module xml_entity_decoder_utf8_core #(
    parameter int PENDING_MAX = xed_pkg::PENDING_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] func
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] is_end_marker
    output logic       m_axis_tlast
);
    import xed_pkg::*;

    localparam int AW = $clog2(PENDING_MAX);

    logic          q_push, q_full, q_pop, q_empty;
    t_cmd          q_in_cmd, q_out_cmd;
    logic          flush_done;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;

    // Matcher and buffer writer
    xed_front #(
        .PENDING_MAX(PENDING_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_func      (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in_cmd),
        .i_flush_done(flush_done),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // Command queue
    xed_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (q_in_cmd),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_cmd  (q_out_cmd),
        .o_empty(q_empty)
    );

    // Pending byte buffer
    xed_ram #(
        .WIDTH(8),
        .DEPTH(PENDING_MAX)
    ) u_pend_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // Replay, encoding and output register
    xed_back #(
        .PENDING_MAX(PENDING_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_q_cmd     (q_out_cmd),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_flush_done(flush_done),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_end       (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

endmodule

// ===== design/xed_checker.sv =====
// Port-level checks for the XML character reference decoder, bound to the top.
// Depends only on the ports of xml_entity_decoder_utf8_core.
module xed_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    // An end marker always closes the run of its transaction
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("end marker without tlast");

    // An end marker carries a zero byte
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'h00)
        else $error("end marker with nonzero data");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Reset leaves the input side ready
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind xml_entity_decoder_utf8_core xed_checker u_xed_checker (.*);

// ===== tb/xml_entity_decoder_utf8_core_tb.sv =====
// Self-checking testbench for the XML character reference decoder core.
// Depends on xed_pkg and xml_entity_decoder_utf8_core; a built-in decoder
// model predicts every output transaction, which is checked in order.
module xml_entity_decoder_utf8_core_tb;
    import xed_pkg::*;

    localparam int DEPTH      = PENDING_MAX_DEF;
    localparam int RAND_BYTES = 100;
    localparam int LIMIT      = 500000;
    localparam int MAX_PRINT  = 40;

    // One input transaction waiting to be sent
    typedef struct {
        logic       func;
        logic [7:0] data;
        bit         drain;   // hold off until every pending output has arrived
    } t_stim;

    // One expected output transaction
    typedef struct packed {
        logic [7:0] data;
        logic       is_end;
        logic       last;
    } t_beat;

    logic       clk     = 1'b0;
    logic       rst_n   = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data  = 8'h00;
    logic       s_user  = 1'b0;
    logic       m_ready = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_data;
    logic       m_user;
    logic       m_last;

    t_stim      stim_q[$];
    t_beat      exp_beats[$];
    logic [7:0] run_bytes[$];
    t_stim      nxt;
    t_beat      want;

    bit in_taken  = 1'b0;
    bit calm      = 1'b0;
    bit hold_done = 1'b0;
    int in_count  = 0;
    int hold_at   = 0;
    int send_gap  = 0;
    int recv_gap  = 0;
    int hold_left = 0;
    int errors    = 0;
    int cycles    = 0;

    // Decoder model state
    t_mode       ref_mode;
    logic [2:0]  name_idx;
    logic [4:0]  name_cand;
    logic [7:0]  pend_buf [DEPTH];
    int          pend_cnt;
    int unsigned ref_val;
    bit          ref_ovf;
    bit          ref_hex;
    bit          ref_neg;

    xml_entity_decoder_utf8_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last)
    );

    always #10 clk = ~clk;

    // ---------------------------------------------------------------
    // Decoder model
    // ---------------------------------------------------------------
    function automatic string entity_name(int k);
        case (k)
            0: return "amp;";
            1: return "lt;";
            2: return "gt;";
            3: return "quot;";
            default: return "apos;";
        endcase
    endfunction

    function automatic logic [7:0] entity_char(int k);
        case (k)
            0: return CH_AMP;
            1: return "<";
            2: return ">";
            3: return "\"";
            default: return "'";
        endcase
    endfunction

    function automatic void clear_ref();
        ref_mode  = M_IDLE;
        name_idx  = '0;
        name_cand = '0;
        pend_cnt  = 0;
        ref_val   = 0;
        ref_ovf   = 1'b0;
        ref_hex   = 1'b0;
        ref_neg   = 1'b0;
    endfunction

    function automatic void replay_pending();
        for (int i = 0; i < pend_cnt; i++)
            run_bytes.push_back(pend_buf[i]);
        clear_ref();
    endfunction

    // Byte seen with no reference open
    function automatic void start_ref(logic [7:0] c);
        if (c == CH_AMP) begin
            clear_ref();
            pend_buf[0] = c;
            pend_cnt    = 1;
            ref_mode    = M_NAME;
            name_cand   = 5'h1F;
        end else begin
            run_bytes.push_back(c);
        end
    endfunction

    function automatic void abandon_ref(logic [7:0] c);
        replay_pending();
        start_ref(c);
    endfunction

    // Buffer a byte; a full buffer aborts the reference
    function automatic bit hold_byte(logic [7:0] c, t_mode m);
        if (pend_cnt >= DEPTH) begin
            abandon_ref(c);
            return 1'b0;
        end
        pend_buf[pend_cnt] = c;
        pend_cnt++;
        ref_mode = m;
        return 1'b1;
    endfunction

    function automatic int digit_val(logic [7:0] c, bit hex);
        if (c >= "0" && c <= "9") return c - "0";
        if (hex && c >= "a" && c <= "f") return c - "a" + 10;
        if (hex && c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    // ';' closes a numeric reference: UTF-8 encode, drop a surrogate, or reject
    function automatic void close_ref(logic [7:0] c);
        int unsigned v;
        v = ref_val;
        if (ref_neg || ref_ovf || v == 0 || v > CODE_MAX) begin
            abandon_ref(c);
            return;
        end
        if (v < 'h80) begin
            run_bytes.push_back(v[7:0]);
        end else if (v < 'h800) begin
            run_bytes.push_back(8'hC0 | v[10:6]);
            run_bytes.push_back(8'h80 | v[5:0]);
        end else if (v >= SURR_LO && v <= SURR_HI) begin
            // surrogate: consumed silently
        end else if (v < 'h10000) begin
            run_bytes.push_back(8'hE0 | v[15:12]);
            run_bytes.push_back(8'h80 | v[11:6]);
            run_bytes.push_back(8'h80 | v[5:0]);
        end else begin
            run_bytes.push_back(8'hF0 | v[20:18]);
            run_bytes.push_back(8'h80 | v[17:12]);
            run_bytes.push_back(8'h80 | v[11:6]);
            run_bytes.push_back(8'h80 | v[5:0]);
        end
        clear_ref();
    endfunction

    function automatic void first_digit(logic [7:0] c);
        int d;
        if (ref_hex && c == "0") begin
            ref_val = 0;
            void'(hold_byte(c, M_ZERO));
            return;
        end
        d = digit_val(c, ref_hex);
        if (d < 0) begin
            abandon_ref(c);
            return;
        end
        ref_val = d;
        void'(hold_byte(c, M_DIGITS));
    endfunction

    function automatic void ws_byte(logic [7:0] c);
        if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            void'(hold_byte(c, M_WS));
        end else if (c == "+" || c == "-") begin
            ref_neg = (c == "-");
            void'(hold_byte(c, M_SIGN));
        end else begin
            first_digit(c);
        end
    endfunction

    function automatic void name_byte(logic [7:0] c);
        logic [4:0] cand;
        int         i;
        string      nm;
        cand = '0;
        i    = name_idx;
        for (int k = 0; k < 5; k++) begin
            nm = entity_name(k);
            if (name_cand[k] && i < nm.len() && nm[i] == c)
                cand[k] = 1'b1;
        end
        if (cand == '0) begin
            abandon_ref(c);
            return;
        end
        for (int k = 0; k < 5; k++) begin
            nm = entity_name(k);
            if (cand[k] && nm.len() == i + 1) begin
                clear_ref();
                run_bytes.push_back(entity_char(k));
                return;
            end
        end
        if (hold_byte(c, M_NAME)) begin
            name_cand = cand;
            name_idx  = 3'(i + 1);
        end
    endfunction

    function automatic void text_byte(logic [7:0] c);
        int          d;
        int unsigned v;
        case (ref_mode)
            M_NAME: begin
                if (name_idx == 0 && c == "#") void'(hold_byte(c, M_HASH));
                else name_byte(c);
            end
            M_HASH: begin
                if (c == "x" || c == "X") begin
                    ref_hex = 1'b1;
                    void'(hold_byte(c, M_WS));
                end else begin
                    // decimal: this byte is read as in the whitespace phase
                    ref_hex  = 1'b0;
                    ref_mode = M_WS;
                    ws_byte(c);
                end
            end
            M_WS:   ws_byte(c);
            M_SIGN: first_digit(c);
            M_ZERO: begin
                if (c == "x" || c == "X") begin
                    void'(hold_byte(c, M_PREFIX));
                end else if (c == ";") begin
                    close_ref(c);
                end else begin
                    d = digit_val(c, 1'b1);
                    if (d < 0) begin
                        abandon_ref(c);
                    end else begin
                        ref_val = d;
                        void'(hold_byte(c, M_DIGITS));
                    end
                end
            end
            M_PREFIX: begin
                d = digit_val(c, 1'b1);
                if (d < 0) begin
                    abandon_ref(c);
                end else begin
                    ref_val = d;
                    void'(hold_byte(c, M_DIGITS));
                end
            end
            M_DIGITS: begin
                if (c == ";") begin
                    close_ref(c);
                end else begin
                    d = digit_val(c, ref_hex);
                    if (d < 0) begin
                        abandon_ref(c);
                    end else begin
                        if (!ref_ovf) begin
                            v = ref_val * (ref_hex ? 16 : 10) + d;
                            if (v > CODE_MAX) ref_ovf = 1'b1;
                            else ref_val = v;
                        end
                        void'(hold_byte(c, M_DIGITS));
                    end
                end
            end
            default: start_ref(c);
        endcase
    endfunction

    // Expected output transactions of one accepted input transaction
    function automatic void predict_item(logic func, logic [7:0] c);
        t_beat b;
        run_bytes.delete();
        if (func) replay_pending();
        else text_byte(c);
        foreach (run_bytes[j]) begin
            b.data   = run_bytes[j];
            b.is_end = 1'b0;
            b.last   = !func && (j == run_bytes.size() - 1);
            exp_beats.push_back(b);
        end
        if (func) begin
            b.data   = 8'h00;
            b.is_end = 1'b1;
            b.last   = 1'b1;
            exp_beats.push_back(b);
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_item(logic func, logic [7:0] b, bit drain);
        t_stim s;
        s.func  = func;
        s.data  = b;
        s.drain = drain;
        stim_q.push_back(s);
    endtask

    task automatic push_text(string s, bit drain);
        for (int i = 0; i < s.len(); i++)
            push_item(1'b0, s[i], drain && i == 0);
    endtask

    task automatic push_repeat(logic [7:0] b, int n);
        for (int i = 0; i < n; i++)
            push_item(1'b0, b, 1'b0);
    endtask

    task automatic push_end();
        push_item(1'b1, 8'($urandom_range(1, 255)), 1'b0);
    endtask

    task automatic push_number(int unsigned v, bit hex);
        int dg [16];
        int n;
        bit upper;
        n     = 0;
        upper = $urandom_range(0, 1);
        do begin
            dg[n] = hex ? v % 16 : v % 10;
            v     = hex ? v / 16 : v / 10;
            n++;
        end while (v != 0);
        for (int i = n - 1; i >= 0; i--) begin
            if (dg[i] < 10) push_item(1'b0, 8'("0" + dg[i]), 1'b0);
            else push_item(1'b0, 8'((upper ? "A" : "a") + dg[i] - 10), 1'b0);
        end
    endtask

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 5))
            0: return 8'd9;
            1: return 8'd10;
            2: return 8'd11;
            3: return 8'd12;
            4: return 8'd13;
            default: return " ";
        endcase
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 11))
            0: return CH_AMP;
            1: return "#";
            2: return ";";
            3: return "x";
            4: return "X";
            5: return "0";
            6: return "9";
            7: return "a";
            8: return "-";
            9: return " ";
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic int unsigned pick_code();
        case ($urandom_range(0, 9))
            0: return $urandom_range(1, 'h7F);
            1: return $urandom_range('h80, 'h7FF);
            2: return $urandom_range('hD800, 'hDFFF);
            3: return $urandom_range('h800, 'hFFFF);
            4, 5: return $urandom_range('h10000, 'h10FFFF);
            6: return 0;
            7: return $urandom_range('h110000, 'hFFFFFF);
            8: return $urandom_range(1, 9);
            default: return $urandom_range(0, 1) ? 'h10FFFF : 'h110000;
        endcase
    endfunction

    // Numeric reference, mostly well formed, sometimes with a sign, a bad value or a broken close
    task automatic push_numeric(bit drain);
        bit hex;
        hex = $urandom_range(0, 1);
        push_item(1'b0, CH_AMP, drain);
        push_item(1'b0, "#", 1'b0);
        if (hex) push_item(1'b0, $urandom_range(0, 1) ? "x" : "X", 1'b0);
        if ($urandom_range(0, 3) == 0) begin
            push_item(1'b0, ws_char(), 1'b0);
            if ($urandom_range(0, 1)) push_item(1'b0, ws_char(), 1'b0);
        end
        if ($urandom_range(0, 5) == 0)
            push_item(1'b0, $urandom_range(0, 2) == 0 ? "-" : "+", 1'b0);
        if (hex && $urandom_range(0, 3) == 0) begin
            push_item(1'b0, "0", 1'b0);
            push_item(1'b0, $urandom_range(0, 1) ? "x" : "X", 1'b0);
        end
        if ($urandom_range(0, 4) == 0) push_repeat("0", $urandom_range(1, 3));
        push_number(pick_code(), hex);
        if ($urandom_range(0, 6) != 0) push_item(1'b0, ";", 1'b0);
        else push_item(1'b0, noise_char(), 1'b0);
    endtask

    task automatic push_fragment();
        int    kind;
        int    cut;
        bit    drain;
        string nm;
        kind  = $urandom_range(0, 99);
        drain = ($urandom_range(0, 24) == 0);
        if (kind < 15) begin
            for (int i = $urandom_range(1, 4); i > 0; i--)
                push_item(1'b0, 8'($urandom_range(1, 255)), drain && i == 1);
        end else if (kind < 35) begin
            nm = entity_name($urandom_range(0, 4));
            push_item(1'b0, CH_AMP, drain);
            if ($urandom_range(0, 3) == 0) begin
                // truncated or corrupted name
                cut = $urandom_range(0, nm.len() - 1);
                for (int i = 0; i < cut; i++) push_item(1'b0, nm[i], 1'b0);
                push_item(1'b0, noise_char(), 1'b0);
            end else begin
                push_text(nm, 1'b0);
            end
        end else if (kind < 80) begin
            push_numeric(drain);
        end else if (kind < 88) begin
            push_end();
        end else if (kind < 92) begin
            // reference that may outgrow the buffer
            push_item(1'b0, CH_AMP, drain);
            push_item(1'b0, "#", 1'b0);
            push_repeat(" ", $urandom_range(DEPTH - 7, DEPTH + 3));
            push_text("7;", 1'b0);
        end else begin
            for (int i = $urandom_range(2, 8); i > 0; i--)
                push_item(1'b0, noise_char(), 1'b0);
        end
    endtask

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= MAX_PRINT) $display("MISMATCH cycle %0d: %s", cycles, msg);
    endtask

    // ---------------------------------------------------------------
    // Sequence: directed strings, random traffic, drain and verdict
    // ---------------------------------------------------------------
    initial begin
        int dir_size;
        clear_ref();

        push_item(1'b1, 8'hA5, 1'b1);
        push_text("&amp;&lt;&gt;&quot;&apos;", 1'b1);
        push_end();
        push_text("&#65;&#x7FF;&#X20AC;&#x10FFFF;&#128;", 1'b1);
        push_end();
        push_text("&#0;&#-5;&#x110000;&#x00;&#99999999;", 1'b1);
        push_end();
        push_text("&#xD800;&#xdfff;", 1'b1);
        push_end();
        push_text("&#x0x;&#x \t+0X1f;&#\n 42;&#xa9;", 1'b1);
        push_end();
        push_text("&am&lt;&#;&#x;&#12a&qu", 1'b1);
        push_end();
        // longest reference that still fits, then one that overflows the buffer
        push_text("&#", 1'b1);
        push_repeat("0", DEPTH - 4);
        push_text("65;&#", 1'b0);
        push_repeat(" ", DEPTH + 8);
        push_text("7;", 1'b0);
        push_end();
        push_item(1'b0, 8'hFF, 1'b1);
        push_item(1'b0, 8'h01, 1'b0);
        push_item(1'b0, 8'h80, 1'b0);
        push_item(1'b0, 8'h7F, 1'b0);
        push_end();

        dir_size = stim_q.size();
        hold_at  = dir_size + 20;
        while (stim_q.size() - dir_size < RAND_BYTES) push_fragment();
        push_end();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || s_valid) @(posedge clk);
        while (exp_beats.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Sender: feeds the input channel from the stimulus queue
    always @(negedge clk) begin
        calm <= (stim_q.size() < 60);
        if (rst_n && (!s_valid || in_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (stim_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if (stim_q[0].drain && exp_beats.size() != 0) begin
                s_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 6);
                s_valid <= 1'b0;
            end else begin
                nxt = stim_q.pop_front();
                s_valid <= 1'b1;
                s_data  <= nxt.data;
                s_user  <= nxt.func;
            end
        end
    end

    // Receiver: random back-pressure plus one long hold-off
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && in_count >= hold_at) begin
            hold_done = 1'b1;
            hold_left = 299;
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: check output transactions, then predict from input ones
    always @(posedge clk) begin
        in_taken <= rst_n && s_valid && s_ready;
        if (rst_n && m_valid && m_ready) begin
            if (exp_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected output data=%02h end=%0b last=%0b",
                                          m_data, m_user, m_last));
            end else begin
                want = exp_beats.pop_front();
                if (!want.is_end && m_data !== want.data)
                    report_mismatch($sformatf("data %02h, expected %02h", m_data, want.data));
                if (m_user !== want.is_end)
                    report_mismatch($sformatf("end marker %0b, expected %0b",
                                              m_user, want.is_end));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b", m_last, want.last));
            end
        end
        if (rst_n && s_valid && s_ready) begin
            predict_item(s_user, s_data);
            in_count++;
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule

// ===== files.f =====
design/xed_pkg.sv
design/xed_ram.sv
design/xed_front.sv
design/xed_queue.sv
design/xed_back.sv
design/xml_entity_decoder_utf8_core.sv
design/xed_checker.sv
tb/xml_entity_decoder_utf8_core_tb.sv
